>>> hdl/flock_separation_cohesion_defines.svh
// ----------------------------------------------------------------------------
// Flock separation and cohesion: assertion macros
// Shared assertion helpers; they compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FLOCK_SEPARATION_COHESION_DEFINES_SVH
`define FLOCK_SEPARATION_COHESION_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define FSC_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define FSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FSC_ASSERT_IMPLIES(lbl, ante, cons)
`define FSC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hdl/fsc_pkg.sv
// ----------------------------------------------------------------------------
// Flock separation and cohesion: package
// Widths, constants, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package fsc_pkg;

  // Batch limit and the count width that holds it.
  localparam int unsigned MAX_NEIGHBORS = 1024;
  localparam int unsigned CNT_W         = 11;

  // Datapath widths.
  localparam int unsigned COORD_W = 32;
  localparam int unsigned DIFF_W  = 33;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned REG_W   = 31;
  localparam int unsigned TOT_W   = 50;
  localparam int unsigned IN_W    = 208;
  localparam int unsigned OUT_W   = 112;

  // Cohesion gain 0.15 in Q0.16.
  localparam logic [13:0] GAIN_Q16 = 14'd9830;

  // Register reset values.
  localparam logic [REG_W-1:0] RADIUS_RST = 31'd153600;
  localparam logic [REG_W-1:0] SEPD_RST   = 31'd38400;

  // Configuration register indexes.
  localparam logic CFG_SEARCH_RADIUS = 1'b0;
  localparam logic CFG_SEPARATION    = 1'b1;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_DIFF,
    S_FILT,
    S_SQ,
    S_SQACC,
    S_RR,
    S_RRCMP,
    S_SS,
    S_SSCMP,
    S_ROOT,
    S_ROOTW,
    S_PM,
    S_PDIV,
    S_PDIVW,
    S_FIN,
    S_CO,
    S_CD,
    S_DMAG,
    S_G0,
    S_G1,
    S_G2,
    S_G3,
    S_CDIVW,
    S_EMIT
  } fsc_state_e;

endpackage

`default_nettype wire

>>> hdl/flock_separation_cohesion.sv
// A skipped neighbour only goes through the filter; an accepted one outside the
// separation distance adds the squared distance and range checks; one inside it also takes a square root
// and three divides on the shared multiplier and divider.
// A last item with allies adds three divides before the result.
// One item at a time; the input is ready only while the sequencer is idle.
// Reset clears the sums, the count, the handshakes and loads default registers.
// ----------------------------------------------------------------------------
// Flock separation and cohesion: top level
// Accumulates separation and cohesion over a batch of neighbours with one
// shared multiplier, a square root unit and a divider under a sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "flock_separation_cohesion_defines.svh"

module flock_separation_cohesion (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // Configuration writes.
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_idx_i,
  input  wire logic [fsc_pkg::REG_W-1:0] cfg_data_i,
  // Neighbour input.
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  // own_x, own_y, own_z, own_kind, other_x, other_y, other_z, other_kind
  input  wire logic [fsc_pkg::IN_W-1:0]  s_axis_tdata,
  // is_self
  input  wire logic                      s_axis_tuser,
  input  wire logic                      s_axis_tlast,
  // Result output.
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // offset_x, offset_y, offset_z, ally_count, zero pad
  output logic [fsc_pkg::OUT_W-1:0]      m_axis_tdata
);

  import fsc_pkg::*;

  fsc_state_e state_q, state_d;

  logic [REG_W-1:0]          radius_q;
  logic [REG_W-1:0]          sepd_q;
  logic [1:0]                idx_q;
  logic signed [COORD_W-1:0] own_q [3];
  logic signed [COORD_W-1:0] oth_q [3];
  logic signed [DIFF_W-1:0]  d_q   [3];
  logic [31:0]               m_q   [3];
  logic [7:0]                own_kind_q;
  logic [7:0]                oth_kind_q;
  logic                      self_q;
  logic                      last_q;
  logic [63:0]               sq_q;
  logic [63:0]               p_q;
  logic [63:0]               lo_q;
  logic [63:0]               num_q;
  logic [31:0]               dist_q;
  logic [31:0]               push_q;
  logic signed [SUM_W-1:0]   diff_q;
  logic [SUM_W-1:0]          diff_mag_q;
  logic                      diff_neg_q;
  logic [31:0]               res_q [3];
  logic signed [SUM_W-1:0]   sep_sum_q [3];
  logic signed [SUM_W-1:0]   coh_sum_q [3];
  logic [CNT_W-1:0]          cnt_q;
  logic                      out_valid_q;
  logic [OUT_W-1:0]          out_data_q;

  logic                      in_xfer;
  logic                      emit_load;
  logic [31:0]               mul_a;
  logic [31:0]               mul_b;
  logic [DIFF_W-1:0]         mag   [3];
  logic                      take;
  logic                      range_ok;
  logic [31:0]               own_mag;
  logic                      sqrt_start;
  logic                      sqrt_busy;
  logic                      sqrt_done;
  logic [31:0]               sqrt_root;
  logic                      div_start;
  logic                      div_busy;
  logic                      div_done;
  logic [63:0]               div_dividend;
  logic [31:0]               div_divisor;
  logic [63:0]               div_quot;
  logic signed [TOT_W-1:0]   coh_term;
  logic signed [TOT_W-1:0]   total;

  // Saturate a wide signed total to 32 bits.
  function automatic logic [31:0] sat32(input logic signed [TOT_W-1:0] v);
    logic [31:0] r;
    if (v > TOT_W'(signed'(33'sh0_7FFF_FFFF))) begin
      r = 32'h7FFF_FFFF;
    end else if (v < TOT_W'(signed'(33'sh1_8000_0000))) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign emit_load = (state_q == S_EMIT) && (!out_valid_q || m_axis_tready);

  // Neighbour filter on the registered differences.
  always_comb begin
    range_ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      mag[i] = d_q[i][DIFF_W-1] ? DIFF_W'(-d_q[i]) : DIFF_W'(d_q[i]);
      if (mag[i] > {2'b00, radius_q}) begin
        range_ok = 1'b0;
      end
    end
    take = !self_q && range_ok && (cnt_q < CNT_W'(MAX_NEIGHBORS)) &&
           !((own_kind_q != 8'd0) && (oth_kind_q != 8'd0) && (own_kind_q != oth_kind_q));
  end

  assign own_mag = own_q[idx_q][COORD_W-1] ? 32'(-own_q[idx_q]) : 32'(own_q[idx_q]);

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SQ: begin
        mul_a = m_q[idx_q];
        mul_b = m_q[idx_q];
      end
      S_RR: begin
        mul_a = {1'b0, radius_q};
        mul_b = {1'b0, radius_q};
      end
      S_SS: begin
        mul_a = {1'b0, sepd_q};
        mul_b = {1'b0, sepd_q};
      end
      S_PM: begin
        mul_a = m_q[idx_q];
        mul_b = push_q;
      end
      S_CO: begin
        mul_a = {21'd0, cnt_q};
        mul_b = own_mag;
      end
      S_G0: begin
        mul_a = diff_mag_q[31:0];
        mul_b = {18'd0, GAIN_Q16};
      end
      S_G1: begin
        mul_a = {16'd0, diff_mag_q[47:32]};
        mul_b = {18'd0, GAIN_Q16};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    p_q <= 64'(mul_a) * 64'(mul_b);
  end

  // Divider operand selection.
  assign div_dividend = (state_q == S_PDIV) ? p_q + {33'd0, dist_q[31:1]}
                                            : num_q + {38'd0, cnt_q, 15'd0};
  assign div_divisor  = (state_q == S_PDIV) ? dist_q : {5'd0, cnt_q, 16'd0};
  assign div_start    = (state_q == S_PDIV) || (state_q == S_G3);
  assign sqrt_start   = (state_q == S_ROOT);

  // Cohesion term with its sign and the axis total before saturation.
  assign coh_term = diff_neg_q ? -$signed({6'd0, div_quot[43:0]})
                               : $signed({6'd0, div_quot[43:0]});
  assign total    = TOT_W'(sep_sum_q[idx_q]) + coh_term;

  fsc_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (sq_q),
    .busy_o     (sqrt_busy),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  fsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_xfer) state_d = S_DIFF;
      S_DIFF:  state_d = S_FILT;
      S_FILT:  state_d = take ? S_SQ : S_FIN;
      S_SQ:    state_d = S_SQACC;
      S_SQACC: state_d = (idx_q == 2'd2) ? S_RR : S_SQ;
      S_RR:    state_d = S_RRCMP;
      S_RRCMP: state_d = ((sq_q != '0) && (sq_q <= p_q)) ? S_SS : S_FIN;
      S_SS:    state_d = S_SSCMP;
      S_SSCMP: state_d = (sq_q < p_q) ? S_ROOT : S_FIN;
      S_ROOT:  state_d = S_ROOTW;
      S_ROOTW: if (sqrt_done) state_d = S_PM;
      S_PM:    state_d = S_PDIV;
      S_PDIV:  state_d = S_PDIVW;
      S_PDIVW: if (div_done) state_d = (idx_q == 2'd2) ? S_FIN : S_PM;
      S_FIN: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (cnt_q == '0) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_CO;
        end
      end
      S_CO:    state_d = S_CD;
      S_CD:    state_d = S_DMAG;
      S_DMAG:  state_d = S_G0;
      S_G0:    state_d = S_G1;
      S_G1:    state_d = S_G2;
      S_G2:    state_d = S_G3;
      S_G3:    state_d = S_CDIVW;
      S_CDIVW: if (div_done) state_d = (idx_q == 2'd2) ? S_EMIT : S_CO;
      S_EMIT:  if (emit_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);

  // State, configuration and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      radius_q    <= RADIUS_RST;
      sepd_q      <= SEPD_RST;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      cnt_q       <= '0;
      for (int i = 0; i < 3; i++) begin
        sep_sum_q[i] <= '0;
        coh_sum_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SEARCH_RADIUS: radius_q <= cfg_data_i;
          CFG_SEPARATION:    sepd_q   <= cfg_data_i;
          default:           radius_q <= radius_q;
        endcase
      end
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      // Axis index walks through the per-axis steps.
      case (state_q)
        S_FILT, S_ROOTW, S_FIN: idx_q <= '0;
        S_SQACC: idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
        S_PDIVW, S_CDIVW: if (div_done) idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
        default: idx_q <= idx_q;
      endcase
      // Cohesion sum and count for an accepted neighbour.
      if ((state_q == S_RRCMP) && (sq_q != '0) && (sq_q <= p_q)) begin
        cnt_q <= cnt_q + CNT_W'(1);
        for (int i = 0; i < 3; i++) begin
          coh_sum_q[i] <= coh_sum_q[i] + SUM_W'(oth_q[i]);
        end
      end
      // Separation push points away from the neighbour.
      if ((state_q == S_PDIVW) && div_done) begin
        if (d_q[idx_q][DIFF_W-1]) begin
          sep_sum_q[idx_q] <= sep_sum_q[idx_q] + $signed(div_quot[SUM_W-1:0]);
        end else begin
          sep_sum_q[idx_q] <= sep_sum_q[idx_q] - $signed(div_quot[SUM_W-1:0]);
        end
      end
      // Batch closes: clear the count and the sums once the result is loaded.
      if (emit_load) begin
        cnt_q <= '0;
        for (int i = 0; i < 3; i++) begin
          sep_sum_q[i] <= '0;
          coh_sum_q[i] <= '0;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          own_q[0]   <= s_axis_tdata[31:0];
          own_q[1]   <= s_axis_tdata[63:32];
          own_q[2]   <= s_axis_tdata[95:64];
          own_kind_q <= s_axis_tdata[103:96];
          oth_q[0]   <= s_axis_tdata[135:104];
          oth_q[1]   <= s_axis_tdata[167:136];
          oth_q[2]   <= s_axis_tdata[199:168];
          oth_kind_q <= s_axis_tdata[207:200];
          self_q     <= s_axis_tuser;
          last_q     <= s_axis_tlast;
        end
      end
      S_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          d_q[i] <= DIFF_W'(oth_q[i]) - DIFF_W'(own_q[i]);
        end
      end
      S_FILT: begin
        sq_q <= '0;
        for (int i = 0; i < 3; i++) begin
          m_q[i] <= mag[i][31:0];
        end
      end
      S_SQACC: sq_q <= sq_q + p_q;
      S_ROOTW: begin
        if (sqrt_done) begin
          dist_q <= sqrt_root;
          push_q <= {1'b0, sepd_q} - sqrt_root;
        end
      end
      S_FIN: begin
        for (int i = 0; i < 3; i++) begin
          res_q[i] <= sat32(TOT_W'(sep_sum_q[i]));
        end
      end
      S_CD: begin
        if (own_q[idx_q][COORD_W-1]) begin
          diff_q <= coh_sum_q[idx_q] + $signed(p_q[SUM_W-1:0]);
        end else begin
          diff_q <= coh_sum_q[idx_q] - $signed(p_q[SUM_W-1:0]);
        end
      end
      S_DMAG: begin
        diff_mag_q <= diff_q[SUM_W-1] ? SUM_W'(-diff_q) : SUM_W'(diff_q);
        diff_neg_q <= diff_q[SUM_W-1];
      end
      S_G1: lo_q  <= p_q;
      S_G2: num_q <= lo_q + {p_q[31:0], 32'd0};
      S_CDIVW: if (div_done) res_q[idx_q] <= sat32(total);
      S_EMIT: begin
        if (emit_load) begin
          out_data_q <= {5'd0, cnt_q, res_q[2], res_q[1], res_q[0]};
        end
      end
      default: begin
        sq_q <= sq_q;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Checks.
  `FSC_ASSERT_IMPLIES(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(MAX_NEIGHBORS))
  `FSC_ASSERT_NEXT(a_emit_clears, emit_load, (cnt_q == '0) && m_axis_tvalid)
  `FSC_ASSERT_IMPLIES(a_div_idle, div_start, !div_busy && !sqrt_busy)

endmodule

`default_nettype wire

>>> hdl/fsc_sqrt.sv
// ----------------------------------------------------------------------------
// Flock separation and cohesion: integer square root
// Digit-by-digit floor square root of a 64-bit value, one root bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fsc_sqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] radicand_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [31:0]      root_o
);

  logic [63:0] rad_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [35:0] rem_sh;
  logic [35:0] trial;

  // Bring down the next two radicand bits and try the next root bit.
  assign rem_sh = {rem_q, rad_q[63:62]};
  assign trial  = {2'b00, root_q, 2'b01};

  // Control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= 34'(rem_sh - trial);
        root_q <= {root_q[30:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[33:0];
        root_q <= {root_q[30:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

>>> hdl/fsc_div.sv
// ----------------------------------------------------------------------------
// Flock separation and cohesion: unsigned divider
// Restoring division of a 64-bit dividend by a nonzero 32-bit divisor,
// one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fsc_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [63:0]      quotient_o
);

  logic [63:0] dq_q;
  logic [31:0] rem_q;
  logic [31:0] den_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [32:0] rem_sh;
  logic        fits;

  // Shift in the next dividend bit and compare against the divisor.
  assign rem_sh = {rem_q, dq_q[63]};
  assign fits   = rem_sh >= {1'b0, den_q};

  // Control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend register fills up with quotient bits.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      dq_q <= {dq_q[62:0], fits};
      if (fits) begin
        rem_q <= 32'(rem_sh - {1'b0, den_q});
      end else begin
        rem_q <= rem_sh[31:0];
      end
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

`default_nettype wire
